// ----- rtl/per_cpu_interrupt_controller_with_ipi_macros.svh -----
// Assertion macros used by the checker file of the interrupt controller.
`ifndef PER_CPU_INTERRUPT_CONTROLLER_WITH_IPI_MACROS_SVH
`define PER_CPU_INTERRUPT_CONTROLLER_WITH_IPI_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define PCIC_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("pcic checker: implication failed");

// Next-cycle implication, disabled while dis is high.
`define PCIC_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("pcic checker: next-cycle implication failed");

`endif

// ----- rtl/pcic_pkg.sv -----
// Types and constants of the per-CPU interrupt controller.
package pcic_pkg;

  // Operation codes of a request.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;
  localparam logic [1:0] OP_ACK   = 2'd3;

  // Register selector codes.
  localparam logic [2:0] REG_CONTROL   = 3'd0;
  localparam logic [2:0] REG_IPI_MASK  = 3'd1;
  localparam logic [2:0] REG_IPI_VALUE = 3'd2;
  localparam logic [2:0] REG_IPI_LOCK  = 3'd3;
  localparam logic [2:0] REG_MSG_HIGH  = 3'd4;
  localparam logic [2:0] REG_MSG_LOW   = 3'd5;

  // Active field sits in bits 20:17 of a control word; the keep mask clears bits 31:17.
  localparam int unsigned ACTIVE_SHIFT  = 17;
  localparam logic [31:0] LOW_KEEP_MASK = 32'h0001_FFFF;

  // Reset value of the active CPU count.
  localparam logic [5:0] ACTIVE_CPUS_RESET = 6'd1;

  // One request item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  cpu_id;
    logic [2:0]  reg_select;
    logic [4:0]  msg_cpu;
    logic [31:0] write_data;
    logic [3:0]  irq_number;
  } req_item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] cpu_lines;
  } rsp_item_t;

  // Contents of the input register.
  typedef struct packed {
    logic      valid;
    req_item_t item;
  } step_t;

endpackage

// ----- rtl/pcic_in_stage.sv -----
// Input register of the interrupt controller pipeline.
module pcic_in_stage import pcic_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  input  logic      free,
  output step_t     step
);

  logic      hold;
  logic      accept;
  logic      step_valid;
  req_item_t step_item;

  // The held item waits only while the result register cannot take its result.
  assign hold      = step_valid && !free;
  assign req_stall = hold;
  assign accept    = req_valid && !hold;

  assign step = '{valid: step_valid, item: step_item};

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else begin
      step_valid <= accept || hold;
    end
  end

  // Payload is captured on each transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      step_item <= req;
    end
  end

endmodule

// ----- rtl/pcic_core.sv -----
// Controller state and the single-pass update logic for one request.
module pcic_core import pcic_pkg::*; #(
  parameter int NUM_CPUS = 4,
  parameter int IPI_IRQ  = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  req_item_t  item,
  input  logic [5:0] active_cpus,
  output rsp_item_t  result
);

  localparam logic [3:0] IPI_NUM = 4'(IPI_IRQ);

  logic [31:0] control_word [NUM_CPUS];
  logic [15:0] pending_bits [NUM_CPUS];
  logic [NUM_CPUS-1:0] line_up;
  logic [31:0] msg_high [NUM_CPUS];
  logic [31:0] msg_low  [NUM_CPUS];
  logic [31:0] ipi_mask;
  logic [31:0] ipi_value;
  logic [31:0] ipi_lock;

  logic [31:0] control_word_next [NUM_CPUS];
  logic [15:0] pending_bits_next [NUM_CPUS];
  logic [NUM_CPUS-1:0] line_up_next;

  logic        is_write;
  logic [31:0] mask_diff;
  logic [31:0] value_diff;
  logic [31:0] mask_low;
  logic [31:0] value_low;
  logic        ipi_raise;
  logic        ipi_ack;
  logic [3:0]  raise_irq;
  logic [3:0]  ack_irq;
  logic [15:0] raise_bit;
  logic [15:0] ack_bit;
  logic        raise_hit;
  logic        ack_hit;
  logic        ctl_hit;
  logic [31:0] ctl_rd;
  logic [31:0] mhi_rd;
  logic [31:0] mlo_rd;
  logic [31:0] rdata;

  // Decode of the IPI register writes: the changed bit that is lowest picks the CPU.
  always_comb begin
    is_write   = item.opcode == OP_WRITE;
    mask_diff  = ipi_mask ^ item.write_data;
    value_diff = ipi_value ^ item.write_data;
    mask_low   = mask_diff & (~mask_diff + 32'd1);
    value_low  = value_diff & (~value_diff + 32'd1);
    ipi_raise  = is_write && item.reg_select == REG_IPI_MASK && (|mask_diff)
                 && (|(item.write_data & mask_diff)) && (|(ipi_value & mask_diff));
    ipi_ack    = is_write && item.reg_select == REG_IPI_VALUE
                 && (|(ipi_value & value_diff));
    raise_irq  = (item.opcode == OP_RAISE) ? item.irq_number : IPI_NUM;
    ack_irq    = (item.opcode == OP_ACK) ? item.irq_number : IPI_NUM;
    raise_bit  = 16'd1 << raise_irq;
    ack_bit    = 16'd1 << ack_irq;
  end

  // Per-CPU next state; at most one event touches a CPU per request.
  always_comb begin
    raise_hit = 1'b0;
    ack_hit   = 1'b0;
    ctl_hit   = 1'b0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      control_word_next[c] = control_word[c];
      pending_bits_next[c] = pending_bits[c];
      line_up_next[c]      = line_up[c];
      raise_hit = (item.opcode == OP_RAISE && 6'(c) < active_cpus)
                  || (ipi_raise && mask_low[c]);
      ack_hit   = (item.opcode == OP_ACK && item.cpu_id == 5'(c))
                  || (ipi_ack && value_low[c]);
      ctl_hit   = is_write && item.reg_select == REG_CONTROL
                  && item.cpu_id == 5'(c);
      if (ctl_hit) begin
        control_word_next[c] = item.write_data;
        if (item.write_data[0] && (|(pending_bits[c] & item.write_data[15:0]))) begin
          line_up_next[c] = 1'b1;
        end
      end else if (raise_hit) begin
        pending_bits_next[c] = pending_bits[c] | raise_bit;
        if (|(control_word[c][15:0] & raise_bit)) begin
          control_word_next[c] = control_word[c]
                                 | (32'(raise_irq) << ACTIVE_SHIFT);
          line_up_next[c] = 1'b1;
        end
      end else if (ack_hit && control_word[c][0]) begin
        control_word_next[c] = control_word[c] & LOW_KEEP_MASK;
        pending_bits_next[c] = pending_bits[c] & ~ack_bit;
        line_up_next[c]      = |(pending_bits[c] & ~ack_bit);
      end
    end
  end

  // Read paths of the per-CPU registers, an and-or select over the CPUs.
  always_comb begin
    ctl_rd = '0;
    mhi_rd = '0;
    mlo_rd = '0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      if (item.cpu_id == 5'(c)) begin
        ctl_rd = ctl_rd | control_word[c];
      end
      if (item.msg_cpu == 5'(c) && 6'(c) < active_cpus) begin
        mhi_rd = mhi_rd | msg_high[c];
        mlo_rd = mlo_rd | msg_low[c];
      end
    end
  end

  // Result of the request.
  always_comb begin
    rdata = '0;
    if (item.opcode == OP_READ) begin
      case (item.reg_select)
        REG_CONTROL:   rdata = ctl_rd;
        REG_IPI_MASK:  rdata = ipi_mask;
        REG_IPI_VALUE: rdata = ipi_value;
        REG_IPI_LOCK:  rdata = ipi_lock;
        REG_MSG_HIGH:  rdata = mhi_rd;
        REG_MSG_LOW:   rdata = mlo_rd;
        default:       rdata = '0;
      endcase
    end
    result.read_data = rdata;
    result.cpu_lines = '0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      result.cpu_lines[c] = line_up_next[c];
    end
  end

  // State registers, updated once for each request that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        control_word[c] <= '0;
        pending_bits[c] <= '0;
        msg_high[c]     <= '0;
        msg_low[c]      <= '0;
      end
      line_up   <= '0;
      ipi_mask  <= '0;
      ipi_value <= '0;
      ipi_lock  <= '0;
    end else if (advance) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        control_word[c] <= control_word_next[c];
        pending_bits[c] <= pending_bits_next[c];
        if (is_write && item.msg_cpu == 5'(c) && 6'(c) < active_cpus) begin
          if (item.reg_select == REG_MSG_HIGH) begin
            msg_high[c] <= item.write_data;
          end
          if (item.reg_select == REG_MSG_LOW) begin
            msg_low[c] <= item.write_data;
          end
        end
      end
      line_up <= line_up_next;
      if (is_write && item.reg_select == REG_IPI_MASK) begin
        ipi_mask <= item.write_data;
      end
      if (is_write && item.reg_select == REG_IPI_VALUE) begin
        ipi_value <= item.write_data;
      end
      if (is_write && item.reg_select == REG_IPI_LOCK) begin
        ipi_lock <= item.write_data;
      end
    end
  end

endmodule

// ----- rtl/pcic_out_stage.sv -----
// Result register of the interrupt controller pipeline.
module pcic_out_stage import pcic_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  rsp_item_t result,
  output logic      free,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  // The register can take a new result when empty or when its content leaves now.
  assign free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= result;
    end
  end

endmodule

// ----- rtl/per_cpu_interrupt_controller_with_ipi.sv -----
// Per-CPU interrupt controller with inter-processor interrupts: top level.
//
// Request channel (req_valid, req_stall, req): one bus read, bus write, irq raise or
// acknowledge per transfer. Every request gives exactly one result on the response
// channel (rsp_valid, rsp_stall, rsp): the read data and the state of all CPU lines.
// A request taken into the input register waits there until the result register can
// take its result; then the update logic writes the state and the result register at
// once, and rsp_valid rises.
// Throughput is one request per cycle while rsp_stall is low, set by the single pass of update logic.
// While the result register is full and stalled, one more request is taken into the
// input register; after that req_stall stays high until the result is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the number of
// active CPUs; it is always ready and is meant to be used only while no request
// is in flight.
// Synchronous reset clears all controller state, empties both pipeline registers
// and sets the active CPU count to one.
module per_cpu_interrupt_controller_with_ipi import pcic_pkg::*; #(
  parameter int NUM_CPUS = 4,
  parameter int IPI_IRQ  = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_item_t  req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_item_t  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  step_t      step;
  logic       free;
  logic       advance;
  rsp_item_t  result;
  logic [5:0] active_cpus;

  // Active CPU count register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cpus <= ACTIVE_CPUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_cpus <= cfg_data;
    end
  end

  // The held request is processed when the result register can take its result.
  assign advance = step.valid && free;

  pcic_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .free      (free),
    .step      (step)
  );

  pcic_core #(
    .NUM_CPUS (NUM_CPUS),
    .IPI_IRQ  (IPI_IRQ)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (step.item),
    .active_cpus (active_cpus),
    .result      (result)
  );

  pcic_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .free      (free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/pcic_checker.sv -----
// Port-level checker of the interrupt controller and its bind statement.
`include "per_cpu_interrupt_controller_with_ipi_macros.svh"

module pcic_checker import pcic_pkg::*; #(
  parameter int NUM_CPUS = 4
) (
  input logic       clk,
  input logic       rst,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input rsp_item_t  rsp
);

  // A stalled result holds until it is taken.
  `PCIC_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Reset empties the result register.
  `PCIC_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !rsp_valid)

  // Requests are held back only by a stalled result.
  `PCIC_ASSERT_IMP(a_stall_cause, clk, rst, req_stall, rsp_valid && rsp_stall)

  // No line is shown for a CPU that does not exist.
  `PCIC_ASSERT_IMP(a_lines_range, clk, rst, rsp_valid, (rsp.cpu_lines >> NUM_CPUS) == 32'd0)

endmodule

bind per_cpu_interrupt_controller_with_ipi pcic_checker #(
  .NUM_CPUS (NUM_CPUS)
) u_pcic_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- bench/tb_per_cpu_interrupt_controller_with_ipi.sv -----
// Self-checking testbench for the per-CPU interrupt controller with IPI support.
`timescale 1ns / 100ps

module tb_per_cpu_interrupt_controller_with_ipi;
  import pcic_pkg::*;

  localparam int NUM_CPUS = 4;
  localparam int IPI_IRQ = 12;
  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_SHOWN = 10;

  // Selector codes that map to no register.
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = '0;

  // Requests waiting to be offered and responses the controller still owes.
  req_item_t pending_reqs[$];
  rsp_item_t awaited_responses[$];

  // Mirror of the controller state.
  logic [31:0] ctrl_words[NUM_CPUS];
  logic [15:0] pend_bits[NUM_CPUS];
  bit cpu_line[NUM_CPUS];
  logic [31:0] ipi_mask_q;
  logic [31:0] ipi_value_q;
  logic [31:0] ipi_lock_q;
  logic [31:0] msg_hi[NUM_CPUS];
  logic [31:0] msg_lo[NUM_CPUS];
  logic [5:0] cpu_count;

  int mismatches = 0;
  int accepted_reqs = 0;
  bit req_fire = 1'b0;
  bit hold_off = 1'b0;
  bit steady_tx = 1'b0;
  bit steady_rx = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  per_cpu_interrupt_controller_with_ipi #(
    .NUM_CPUS(NUM_CPUS),
    .IPI_IRQ(IPI_IRQ)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Raise an irq on one CPU: set pending, and latch it as active where the mask allows.
  function automatic void raise_irq(int unsigned cpu, logic [3:0] irq);
    if (cpu >= NUM_CPUS) return;
    pend_bits[cpu] = pend_bits[cpu] | (16'd1 << irq);
    if (ctrl_words[cpu][irq]) begin
      ctrl_words[cpu] = ctrl_words[cpu] | (32'(irq) << ACTIVE_SHIFT);
      cpu_line[cpu] = pend_bits[cpu] != 0;
    end
  endfunction

  // Acknowledge an irq on an enabled CPU.
  function automatic void ack_irq(int unsigned cpu, logic [3:0] irq);
    if (cpu >= NUM_CPUS) return;
    if (!ctrl_words[cpu][0]) return;
    ctrl_words[cpu] = ctrl_words[cpu] & LOW_KEEP_MASK;
    pend_bits[cpu] = pend_bits[cpu] & ~(16'd1 << irq);
    cpu_line[cpu] = pend_bits[cpu] != 0;
  endfunction

  function automatic int unsigned lowest_set(logic [31:0] v);
    int unsigned n;
    n = 0;
    while (n < 31 && !v[n]) n++;
    return n;
  endfunction

  // Apply one request to the mirror and return the response it must produce.
  function automatic rsp_item_t apply_request(req_item_t r);
    rsp_item_t o;
    logic [31:0] old;
    logic [31:0] diff;
    int unsigned served;
    bit msg_ok;
    bit cpu_ok;
    o = '0;
    served = (cpu_count < NUM_CPUS) ? cpu_count : NUM_CPUS;
    msg_ok = r.msg_cpu < served;
    cpu_ok = r.cpu_id < NUM_CPUS;
    case (r.opcode)
      OP_READ: begin
        case (r.reg_select)
          REG_CONTROL: o.read_data = cpu_ok ? ctrl_words[r.cpu_id] : '0;
          REG_IPI_MASK: o.read_data = ipi_mask_q;
          REG_IPI_VALUE: o.read_data = ipi_value_q;
          REG_IPI_LOCK: o.read_data = ipi_lock_q;
          REG_MSG_HIGH: o.read_data = msg_ok ? msg_hi[r.msg_cpu] : '0;
          REG_MSG_LOW: o.read_data = msg_ok ? msg_lo[r.msg_cpu] : '0;
          default: o.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (r.reg_select)
          REG_CONTROL: begin
            if (cpu_ok) begin
              ctrl_words[r.cpu_id] = r.write_data;
              if (r.write_data[0] && (pend_bits[r.cpu_id] & r.write_data[15:0]) != 0)
                cpu_line[r.cpu_id] = 1'b1;
            end
          end
          REG_IPI_MASK: begin
            diff = ipi_mask_q ^ r.write_data;
            ipi_mask_q = r.write_data;
            if (diff != 0 && (r.write_data & diff) != 0 && (ipi_value_q & diff) != 0)
              raise_irq(lowest_set(diff), 4'(IPI_IRQ));
          end
          REG_IPI_VALUE: begin
            old = ipi_value_q;
            diff = old ^ r.write_data;
            ipi_value_q = r.write_data;
            if (diff != 0 && (old & diff) != 0)
              ack_irq(lowest_set(diff), 4'(IPI_IRQ));
          end
          REG_IPI_LOCK: ipi_lock_q = r.write_data;
          REG_MSG_HIGH: if (msg_ok) msg_hi[r.msg_cpu] = r.write_data;
          REG_MSG_LOW: if (msg_ok) msg_lo[r.msg_cpu] = r.write_data;
          default: ;
        endcase
      end
      OP_RAISE: begin
        for (int c = 0; c < served; c++) raise_irq(c, r.irq_number);
      end
      default: ack_irq(r.cpu_id, r.irq_number);
    endcase
    for (int c = 0; c < NUM_CPUS; c++) o.cpu_lines[c] = cpu_line[c];
    return o;
  endfunction

  function automatic req_item_t make_req(logic [1:0] op, logic [4:0] cpu, logic [2:0] sel,
                                         logic [4:0] mcpu, logic [31:0] wd, logic [3:0] irq);
    req_item_t r;
    r.opcode = op;
    r.cpu_id = cpu;
    r.reg_select = sel;
    r.msg_cpu = mcpu;
    r.write_data = wd;
    r.irq_number = irq;
    return r;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Loose request with every field drawn wide; biased toward reachable CPUs.
  function automatic req_item_t random_request();
    req_item_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.opcode = (pick < 20) ? OP_READ : (pick < 55) ? OP_WRITE : (pick < 78) ? OP_RAISE : OP_ACK;
    r.cpu_id = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, NUM_CPUS - 1))
                                             : 5'($urandom_range(0, 31));
    r.reg_select = 3'($urandom_range(0, 7));
    r.msg_cpu = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, NUM_CPUS))
                                              : 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 3);
    if (pick == 0) r.write_data = 32'($urandom_range(0, 15));
    else if (pick == 1) r.write_data = 32'd1 << $urandom_range(0, 31);
    else r.write_data = $urandom;
    r.irq_number = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Well-formed flows: program a CPU, raise, look, acknowledge; or an IPI round trip.
  function automatic int queue_flow();
    logic [4:0] c;
    logic [3:0] irq;
    logic [31:0] wd;
    c = 5'($urandom_range(0, NUM_CPUS - 1));
    irq = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    wd = $urandom;
    wd[0] = $urandom_range(0, 7) != 0;
    if ($urandom_range(0, 2) != 0) begin
      wd[irq] = $urandom_range(0, 3) != 0;
      pending_reqs.push_back(make_req(OP_WRITE, c, REG_CONTROL, '0, wd, '0));
      pending_reqs.push_back(make_req(OP_RAISE, c, REG_CONTROL, '0, '0, irq));
      pending_reqs.push_back(make_req(OP_READ, c, REG_CONTROL, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_ACK, c, REG_CONTROL, '0, '0, irq));
      pending_reqs.push_back(make_req(OP_READ, c, REG_CONTROL, '0, '0, '0));
      return 5;
    end
    wd[IPI_IRQ] = 1'b1;
    pending_reqs.push_back(make_req(OP_WRITE, c, REG_CONTROL, '0, wd, '0));
    pending_reqs.push_back(make_req(OP_WRITE, c, REG_IPI_VALUE, '0,
                                    ($urandom & 32'hFFFF_FFF0) | (32'd1 << c), '0));
    pending_reqs.push_back(make_req(OP_WRITE, c, REG_IPI_MASK, '0,
                                    ($urandom & 32'hFFFF_FFF0) | (32'd1 << c), '0));
    pending_reqs.push_back(make_req(OP_READ, c, REG_IPI_MASK, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_WRITE, c, REG_IPI_VALUE, '0, '0, '0));
    return 5;
  endfunction

  // Wait until every queued request has been transferred and answered.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || req_valid || awaited_responses.size() != 0);
  endtask

  // Write the active CPU count while the controller is idle.
  task automatic write_cpu_count(logic [5:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Request driver: a stalled transfer holds its payload, otherwise gaps are inserted.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (gap_left != 0) begin
        req_valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        gap_left = (steady_tx || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if ($urandom_range(0, 149) == 0) steady_tx = !steady_tx;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response receiver: random stalls, quiet stretches, and the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_off) begin
      rsp_stall <= 1'b1;
    end else if (stall_left != 0) begin
      rsp_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
      if (!steady_rx && $urandom_range(0, 3) == 0) stall_left = idle_length();
    end
    if ($urandom_range(0, 499) == 0) steady_rx = !steady_rx;
  end

  // Long receiver hold-off so the pipeline fills and back-pressures requests.
  initial begin
    wait (accepted_reqs >= HOLD_AFTER);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: track configuration, predict each request, check each response.
  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        ctrl_words[c] = '0;
        pend_bits[c] = '0;
        cpu_line[c] = 1'b0;
        msg_hi[c] = '0;
        msg_lo[c] = '0;
      end
      ipi_mask_q = '0;
      ipi_value_q = '0;
      ipi_lock_q = '0;
      cpu_count = ACTIVE_CPUS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) cpu_count = cfg_data;
      if (rsp_valid && !rsp_stall) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: response with none outstanding: read_data %h cpu_lines %h",
                     $realtime, rsp.read_data, rsp.cpu_lines);
        end else begin
          rsp_item_t exp_rsp;
          exp_rsp = awaited_responses.pop_front();
          if (rsp.read_data !== exp_rsp.read_data || rsp.cpu_lines !== exp_rsp.cpu_lines) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: mismatch: read_data exp %h got %h, cpu_lines exp %h got %h",
                       $realtime, exp_rsp.read_data, rsp.read_data,
                       exp_rsp.cpu_lines, rsp.cpu_lines);
          end
        end
      end
      if (req_valid && !req_stall) begin
        awaited_responses.push_back(apply_request(req));
        accepted_reqs++;
      end
    end
    req_fire <= !rst && req_valid && !req_stall;
  end

  // Stimulus: directed corner cases, then random phases over several CPU counts.
  initial begin
    logic [5:0] counts[7];
    int n;
    counts = '{6'd1, 6'd0, 6'd2, 6'd63, 6'd32, 6'd3, 6'd4};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_cpu_count(6'd4);

    // Raise and acknowledge paths, including irq zero and a disabled CPU.
    pending_reqs.push_back(make_req(OP_READ, 5'd0, REG_CONTROL, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_CONTROL, '0, 32'hFFFF_FFFF, '0));
    pending_reqs.push_back(make_req(OP_RAISE, 5'd0, REG_CONTROL, '0, '0, 4'd15));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, REG_CONTROL, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd1, REG_CONTROL, '0, 32'h0, '0));
    pending_reqs.push_back(make_req(OP_RAISE, 5'd3, REG_CONTROL, '0, '0, 4'd0));
    pending_reqs.push_back(make_req(OP_ACK, 5'd1, REG_CONTROL, '0, '0, 4'd15));
    pending_reqs.push_back(make_req(OP_ACK, 5'd0, REG_CONTROL, '0, '0, 4'd15));
    pending_reqs.push_back(make_req(OP_ACK, 5'd0, REG_CONTROL, '0, '0, 4'd0));
    // CPU index beyond the controller.
    pending_reqs.push_back(make_req(OP_WRITE, 5'd31, REG_CONTROL, '0, 32'hFFFF_FFFF, '0));
    pending_reqs.push_back(make_req(OP_READ, 5'd31, REG_CONTROL, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_ACK, 5'd31, REG_CONTROL, '0, '0, 4'd3));
    // Control write that meets already pending bits raises the line.
    pending_reqs.push_back(make_req(OP_WRITE, 5'd2, REG_CONTROL, '0, 32'h0000_8001, '0));
    // IPI raise, acknowledge, and a raise aimed past the last CPU.
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_IPI_VALUE, '0, 32'h0000_000F, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_IPI_MASK, '0, 32'h0000_0001, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_IPI_MASK, '0, 32'h8000_0000, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_IPI_VALUE, '0, 32'hFFFF_FFF0, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_IPI_MASK, '0, 32'h0000_0010, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_IPI_LOCK, '0, 32'hFFFF_FFFF, '0));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, REG_IPI_LOCK, '0, '0, '0));
    // Message registers, in and out of range, and unmapped selects.
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_MSG_HIGH, 5'd3, 32'hA5A5_5A5A, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_MSG_LOW, 5'd31, 32'hFFFF_FFFF, '0));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, REG_MSG_HIGH, 5'd3, '0, '0));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, REG_MSG_LOW, 5'd31, '0, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 5'd0, REG_UNMAPPED_LO, '0, 32'hFFFF_FFFF, '0));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, REG_UNMAPPED_HI, '0, '0, '0));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, REG_IPI_MASK, '0, '0, '0));

    // Random phases, each under its own active CPU count.
    foreach (counts[i]) begin
      write_cpu_count(counts[i]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 45) begin
          n += queue_flow();
        end else begin
          pending_reqs.push_back(random_request());
          n++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("tb_per_cpu_interrupt_controller_with_ipi OK");
    end else begin
      $display("tb_per_cpu_interrupt_controller_with_ipi NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("tb_per_cpu_interrupt_controller_with_ipi NOT OK");
    $finish;
  end

endmodule
